// ===== rtl/periodic_task_timer_table_assert.svh =====
// assertion macros used by the timer table execution unit
`ifndef PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH
// condition that holds at every clock edge out of reset
`define PTT_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// implication checked in the same cycle
`define PTT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`endif

// ===== rtl/ptt_pkg.sv =====
// types, codes and constants of the timer table
`default_nettype none
package ptt_pkg;
	localparam int SLOT_COUNT = 8;
	localparam int TIME_BITS  = 32;
	localparam int TAG_BITS   = 16;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int LEN_W      = $clog2(SLOT_COUNT + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

	// port field widths
	localparam int CMD_W      = 4;
	localparam int ID_W       = 4;
	localparam int VAL_W      = 32;
	localparam int TAGP_W     = 16;
	localparam int STEP_W     = 16;
	localparam int CODE_W     = 2;
	localparam int SLOTP_W    = 3;
	localparam int CNT_W      = 8;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [TAG_BITS-1:0]  tag_t;
	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [LEN_W-1:0]     len_t;

	localparam logic [CMD_W-1:0] CMD_ADD     = 4'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE  = 4'd1;
	localparam logic [CMD_W-1:0] CMD_START   = 4'd2;
	localparam logic [CMD_W-1:0] CMD_STOP    = 4'd3;
	localparam logic [CMD_W-1:0] CMD_REWIND  = 4'd4;
	localparam logic [CMD_W-1:0] CMD_SETPER  = 4'd5;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 4'd6;
	localparam logic [CMD_W-1:0] CMD_TICK    = 4'd7;
	localparam logic [CMD_W-1:0] CMD_PROCESS = 4'd8;

	localparam logic [CODE_W-1:0] ST_OK     = 2'd0;
	localparam logic [CODE_W-1:0] ST_PARAM  = 2'd1;
	localparam logic [CODE_W-1:0] ST_UNUSED = 2'd2;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_FIRE   = 1'b1;

	typedef enum logic [3:0] {
		OP_ADD, OP_DEL, OP_START, OP_STOP, OP_REWIND,
		OP_SETPER, OP_QUERY, OP_TICK, OP_PROC, OP_BAD
	} op_t;

	typedef struct packed {
		op_t   op;
		logic  in_range;
		slot_t slot;
		logic  free_kind;
		logic  add_reject;
		logic  per_zero;
		time_t period;
		time_t delay;
		tag_t  tag;
	} cmd_t;

	typedef enum logic [3:0] {
		BK_IDLE, BK_EXEC, BK_DEL, BK_FR, BK_FR_CHK,
		BK_PR, BK_PR_CHK, BK_PR_DIV, BK_PR_EMIT, BK_STATUS
	} back_state_t;
endpackage
`default_nettype wire

// ===== rtl/ptt_if.sv =====
// command and result channel interfaces of the timer table
`default_nettype none
interface ptt_in_if;
	logic                         valid;
	logic                         ready;
	logic [ptt_pkg::CMD_W-1:0]    command;
	logic [ptt_pkg::ID_W-1:0]     slot_id;
	logic                         task_kind;
	logic [ptt_pkg::VAL_W-1:0]    period_value;
	logic [ptt_pkg::VAL_W-1:0]    start_delay;
	logic [ptt_pkg::TAGP_W-1:0]   handler_tag;
	modport source (output valid, command, slot_id, task_kind, period_value,
		start_delay, handler_tag, input ready);
	modport sink (input valid, command, slot_id, task_kind, period_value,
		start_delay, handler_tag, output ready);
endinterface

interface ptt_out_if;
	logic                         valid;
	logic                         ready;
	logic                         item_kind;
	logic [ptt_pkg::CODE_W-1:0]   status_code;
	logic [ptt_pkg::SLOTP_W-1:0]  slot_number;
	logic [ptt_pkg::TAGP_W-1:0]   fired_tag;
	logic [ptt_pkg::CNT_W-1:0]    fire_count;
	logic                         is_running;
	logic                         last_item;
	modport source (output valid, item_kind, status_code, slot_number, fired_tag,
		fire_count, is_running, last_item, input ready);
	modport sink (input valid, item_kind, status_code, slot_number, fired_tag,
		fire_count, is_running, last_item, output ready);
endinterface
`default_nettype wire

// ===== rtl/ptt_front.sv =====
// command decode stage in front of the queue
`default_nettype none
module ptt_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ptt_in_if.sink           req,
	output ptt_pkg::cmd_t    push_cmd,
	output logic             push_valid,
	input  wire logic        push_ready
);
	import ptt_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t dec;

	always_comb begin
		dec = '0;
		unique case (req.command)
			CMD_ADD:     dec.op = OP_ADD;
			CMD_DELETE:  dec.op = OP_DEL;
			CMD_START:   dec.op = OP_START;
			CMD_STOP:    dec.op = OP_STOP;
			CMD_REWIND:  dec.op = OP_REWIND;
			CMD_SETPER:  dec.op = OP_SETPER;
			CMD_QUERY:   dec.op = OP_QUERY;
			CMD_TICK:    dec.op = OP_TICK;
			CMD_PROCESS: dec.op = OP_PROC;
			default:     dec.op = OP_BAD;
		endcase
		dec.in_range  = int'(req.slot_id) < SLOT_COUNT;
		dec.slot      = slot_t'(req.slot_id);
		dec.free_kind = req.task_kind;
		dec.period    = time_t'(req.period_value);
		dec.delay     = time_t'(req.start_delay);
		dec.tag       = tag_t'(req.handler_tag);
		dec.per_zero  = (dec.period == '0);
		dec.add_reject = (dec.tag == '0) || (!req.task_kind && dec.per_zero);
	end

	assign req.ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			cmd_s1 <= dec;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ptt_queue.sv =====
// short command queue between decode and execution
`default_nettype none
module ptt_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  ptt_pkg::cmd_t    push_cmd,
	input  wire logic        push_valid,
	output logic             push_ready,
	output ptt_pkg::cmd_t    pop_cmd,
	output logic             pop_valid,
	input  wire logic        pop
);
	import ptt_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (int'(cnt_q) < QUEUE_DEPTH);
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (int'(wr_q) == QUEUE_DEPTH - 1) ? '0 : QPTR_W'(wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= (int'(rd_q) == QUEUE_DEPTH - 1) ? '0 : QPTR_W'(rd_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= QCNT_W'(cnt_q + 1'b1);
			end else if (do_pop && !do_push) begin
				cnt_q <= QCNT_W'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ptt_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module ptt_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  ptt_pkg::time_t     dividend,
	input  ptt_pkg::time_t     divisor,
	output logic               done,
	output ptt_pkg::time_t     quot,
	output ptt_pkg::time_t     rem
);
	import ptt_pkg::*;

	localparam int CW = $clog2(TIME_BITS + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	time_t             rem_q;
	time_t             quo_q;
	time_t             dvs_q;
	logic [TIME_BITS:0] shifted;
	logic [TIME_BITS:0] diff;

	assign shifted = {rem_q, quo_q[TIME_BITS-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign done    = done_q;
	assign quot    = quo_q;
	assign rem     = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(TIME_BITS);
			end else if (busy_q) begin
				cnt_q <= CW'(cnt_q - 1'b1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[TIME_BITS]) begin
				rem_q <= diff[TIME_BITS-1:0];
				quo_q <= {quo_q[TIME_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted[TIME_BITS-1:0];
				quo_q <= {quo_q[TIME_BITS-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ptt_back.sv =====
// execution unit: slot table, order lists, time base and result register
`default_nettype none
module ptt_back (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  ptt_pkg::cmd_t                 q_cmd,
	input  wire logic                     q_valid,
	output logic                          q_pop,
	input  wire logic                     cfg_wr_en,
	input  wire logic [ptt_pkg::STEP_W-1:0] cfg_wr_data,
	ptt_out_if.source                     rsp
);
	import ptt_pkg::*;

	localparam time_t T_HALF = {1'b1, {(TIME_BITS-1){1'b0}}};
	localparam time_t T_ONE  = time_t'(1);

	back_state_t state_q, state_d;

	logic [SLOT_COUNT-1:0] in_use_q, active_q, free_q;
	time_t period_q   [SLOT_COUNT];
	time_t deadline_q [SLOT_COUNT];
	tag_t  handler_q  [SLOT_COUNT];
	slot_t forder_q   [SLOT_COUNT];
	slot_t porder_q   [SLOT_COUNT];
	len_t  fr_len_q, pr_len_q;
	time_t ct_q;
	logic  pend_q;
	logic [STEP_W-1:0] step_q;

	cmd_t  cmd_q;
	len_t  idx_q;
	slot_t cur_q;
	logic  big_q;
	time_t dvd_q, dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CODE_W-1:0] st_code_q;
	slot_t st_slot_q;
	logic  st_run_q;

	logic out_valid_q, o_kind_q, o_run_q, o_last_q;
	logic [CODE_W-1:0] o_code_q;
	slot_t o_slot_q;
	tag_t  o_tag_q;
	logic [CNT_W-1:0] o_cnt_q;

	// datapath helpers
	logic  out_free, out_load;
	logic  o_kind_d, o_run_d, o_last_d;
	logic [CODE_W-1:0] o_code_d;
	slot_t o_slot_d;
	logic [CNT_W-1:0] o_cnt_d;
	logic  have_free;
	slot_t free_idx;
	logic  s_used;
	logic  del_list_free;
	len_t  del_len;
	slot_t del_entry;
	logic  fr_fire, pr_due, p_zero, p_big;
	time_t elapsed, cur_period, dvd_d, dvs_d;
	logic  div_start, div_done;
	time_t div_quot, div_rem;

	assign out_free = !out_valid_q || rsp.ready;
	assign s_used   = in_use_q[cmd_q.slot];
	assign del_list_free = free_q[cur_q];
	assign del_len   = del_list_free ? fr_len_q : pr_len_q;
	assign del_entry = del_list_free ? forder_q[idx_q[SLOT_W-1:0]]
		: porder_q[idx_q[SLOT_W-1:0]];
	assign fr_fire   = active_q[cur_q] && (handler_q[cur_q] != '0);
	assign elapsed   = ct_q - deadline_q[cur_q];
	assign cur_period = period_q[cur_q];
	assign pr_due    = active_q[cur_q] && !elapsed[TIME_BITS-1];
	assign p_zero    = (cur_period == '0);
	assign p_big     = (cur_period > T_HALF);
	assign dvd_d     = p_big ? time_t'(T_HALF - T_ONE - elapsed) : elapsed;
	assign dvs_d     = p_big ? time_t'(-cur_period) : cur_period;

	// lowest free slot
	always_comb begin
		have_free = 1'b0;
		free_idx  = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				have_free = 1'b1;
				free_idx  = slot_t'(i);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) state_d = BK_EXEC;
			end
			BK_EXEC: begin
				if (cmd_q.op == OP_PROC) state_d = BK_FR;
				else if (cmd_q.op == OP_DEL && cmd_q.in_range && s_used) state_d = BK_DEL;
				else state_d = BK_STATUS;
			end
			BK_DEL: begin
				if (idx_q >= del_len || del_entry == cur_q) state_d = BK_STATUS;
			end
			BK_FR: begin
				if (idx_q < fr_len_q) state_d = BK_FR_CHK;
				else if (pend_q) state_d = BK_PR;
				else state_d = BK_STATUS;
			end
			BK_FR_CHK: begin
				if (!fr_fire || out_free) state_d = BK_FR;
			end
			BK_PR: begin
				if (idx_q < pr_len_q) state_d = BK_PR_CHK;
				else state_d = BK_STATUS;
			end
			BK_PR_CHK: begin
				if (!pr_due) state_d = BK_PR;
				else if (p_zero) state_d = BK_PR_EMIT;
				else state_d = BK_PR_DIV;
			end
			BK_PR_DIV: begin
				if (div_done) state_d = BK_PR_EMIT;
			end
			BK_PR_EMIT: begin
				if (out_free) state_d = BK_PR;
			end
			BK_STATUS: begin
				if (out_free) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		q_pop     = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		o_kind_d  = KIND_STATUS;
		o_code_d  = ST_OK;
		o_slot_d  = '0;
		o_cnt_d   = '0;
		o_run_d   = 1'b0;
		o_last_d  = 1'b0;
		unique case (state_q)
			BK_IDLE:   q_pop = q_valid;
			BK_PR_CHK: div_start = pr_due && !p_zero;
			BK_FR_CHK: begin
				out_load = fr_fire && out_free;
				o_kind_d = KIND_FIRE;
				o_slot_d = cur_q;
				o_cnt_d  = CNT_W'(1);
			end
			BK_PR_EMIT: begin
				out_load = out_free;
				o_kind_d = KIND_FIRE;
				o_slot_d = cur_q;
				o_cnt_d  = cnt_q;
			end
			BK_STATUS: begin
				out_load = out_free;
				o_code_d = st_code_q;
				o_slot_d = st_slot_q;
				o_run_d  = st_run_q;
				o_last_d = 1'b1;
			end
			default: ;
		endcase
	end

	ptt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_d),
		.divisor  (dvs_d),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			in_use_q    <= '0;
			active_q    <= '0;
			free_q      <= '0;
			fr_len_q    <= '0;
			pr_len_q    <= '0;
			ct_q        <= '0;
			pend_q      <= 1'b0;
			step_q      <= STEP_W'(1);
			out_valid_q <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				period_q[i]   <= '0;
				deadline_q[i] <= '0;
				handler_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) step_q <= cfg_wr_data;
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;

			unique case (state_q)
				BK_EXEC: begin
					unique case (cmd_q.op)
						OP_ADD: begin
							if (!cmd_q.add_reject && have_free) begin
								in_use_q[free_idx]   <= 1'b1;
								active_q[free_idx]   <= 1'b0;
								free_q[free_idx]     <= cmd_q.free_kind;
								handler_q[free_idx]  <= cmd_q.tag;
								period_q[free_idx]   <= cmd_q.period;
								deadline_q[free_idx] <= ct_q + cmd_q.delay;
								if (cmd_q.free_kind) fr_len_q <= LEN_W'(fr_len_q + 1'b1);
								else pr_len_q <= LEN_W'(pr_len_q + 1'b1);
							end
						end
						OP_START: if (cmd_q.in_range && s_used) active_q[cmd_q.slot] <= 1'b1;
						OP_STOP:  if (cmd_q.in_range && s_used) active_q[cmd_q.slot] <= 1'b0;
						OP_REWIND: begin
							if (cmd_q.in_range && s_used) deadline_q[cmd_q.slot] <= ct_q;
						end
						OP_SETPER: begin
							if (cmd_q.in_range && s_used && !cmd_q.per_zero)
								period_q[cmd_q.slot] <= cmd_q.period;
						end
						OP_TICK: begin
							ct_q   <= ct_q + time_t'(step_q);
							pend_q <= 1'b1;
						end
						default: ;
					endcase
				end
				BK_DEL: begin
					if (idx_q >= del_len || del_entry == cur_q) begin
						// slot is freed whether or not it was listed
						in_use_q[cur_q]   <= 1'b0;
						active_q[cur_q]   <= 1'b0;
						handler_q[cur_q]  <= '0;
						period_q[cur_q]   <= '0;
						deadline_q[cur_q] <= '0;
						if (idx_q < del_len) begin
							if (del_list_free) fr_len_q <= LEN_W'(fr_len_q - 1'b1);
							else pr_len_q <= LEN_W'(pr_len_q - 1'b1);
						end
					end
				end
				BK_FR: begin
					if (idx_q >= fr_len_q && pend_q) pend_q <= 1'b0;
				end
				BK_PR_DIV: begin
					if (div_done) begin
						if (big_q) deadline_q[cur_q] <= deadline_q[cur_q] - dvd_q + div_rem - dvs_q;
						else deadline_q[cur_q] <= ct_q - div_rem + cur_period;
					end
				end
				default: ;
			endcase
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					cmd_q <= q_cmd;
					cur_q <= q_cmd.slot;
					idx_q <= '0;
				end
			end
			BK_EXEC: begin
				st_code_q <= ST_OK;
				st_slot_q <= '0;
				st_run_q  <= 1'b0;
				unique case (cmd_q.op)
					OP_ADD: begin
						if (cmd_q.add_reject || !have_free) st_code_q <= ST_UNUSED;
						else begin
							st_slot_q <= free_idx;
							if (cmd_q.free_kind) forder_q[fr_len_q[SLOT_W-1:0]] <= free_idx;
							else porder_q[pr_len_q[SLOT_W-1:0]] <= free_idx;
						end
					end
					OP_DEL, OP_START, OP_STOP, OP_REWIND, OP_SETPER: begin
						if (!cmd_q.in_range) st_code_q <= ST_PARAM;
						else if (!s_used) st_code_q <= ST_UNUSED;
						else if (cmd_q.op == OP_SETPER && cmd_q.per_zero) st_code_q <= ST_PARAM;
					end
					OP_QUERY: begin
						if (!cmd_q.in_range) st_code_q <= ST_PARAM;
						else st_run_q <= s_used && active_q[cmd_q.slot];
					end
					OP_BAD: st_code_q <= ST_PARAM;
					default: ;
				endcase
			end
			BK_DEL: begin
				if (idx_q < del_len && del_entry == cur_q) begin
					// close the gap
					for (int j = 0; j < SLOT_COUNT - 1; j++) begin
						if (LEN_W'(j) >= idx_q) begin
							if (del_list_free) forder_q[j] <= forder_q[j+1];
							else porder_q[j] <= porder_q[j+1];
						end
					end
				end else if (idx_q < del_len) begin
					idx_q <= LEN_W'(idx_q + 1'b1);
				end
			end
			BK_FR: begin
				if (idx_q < fr_len_q) cur_q <= forder_q[idx_q[SLOT_W-1:0]];
				else idx_q <= '0;
			end
			BK_FR_CHK: begin
				if (!fr_fire || out_free) idx_q <= LEN_W'(idx_q + 1'b1);
			end
			BK_PR: begin
				if (idx_q < pr_len_q) cur_q <= porder_q[idx_q[SLOT_W-1:0]];
			end
			BK_PR_CHK: begin
				if (!pr_due) idx_q <= LEN_W'(idx_q + 1'b1);
				else if (p_zero) cnt_q <= '1;
				else begin
					big_q <= p_big;
					dvd_q <= dvd_d;
					dvs_q <= dvs_d;
				end
			end
			BK_PR_DIV: begin
				if (div_done) begin
					if (div_quot >= time_t'(255)) cnt_q <= '1;
					else cnt_q <= CNT_W'(div_quot + T_ONE);
				end
			end
			BK_PR_EMIT: begin
				if (out_free) idx_q <= LEN_W'(idx_q + 1'b1);
			end
			default: ;
		endcase

		if (out_load) begin
			o_kind_q <= o_kind_d;
			o_code_q <= o_code_d;
			o_slot_q <= o_slot_d;
			o_tag_q  <= (o_kind_d == KIND_FIRE) ? handler_q[cur_q] : '0;
			o_cnt_q  <= o_cnt_d;
			o_run_q  <= o_run_d;
			o_last_q <= o_last_d;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.item_kind   = o_kind_q;
	assign rsp.status_code = o_code_q;
	assign rsp.slot_number = SLOTP_W'(o_slot_q);
	assign rsp.fired_tag   = TAGP_W'(o_tag_q);
	assign rsp.fire_count  = o_cnt_q;
	assign rsp.is_running  = o_run_q;
	assign rsp.last_item   = o_last_q;

`include "periodic_task_timer_table_assert.svh"

	`PTT_ASSERT(a_lists_cover_slots, $countones(in_use_q) == int'(fr_len_q) + int'(pr_len_q), "order lists out of step with slots in use")
	`PTT_ASSERT_IMP(a_div_done_waited, div_done, state_q == BK_PR_DIV, "divider result with no catch-up waiting")
	`PTT_ASSERT_IMP(a_last_is_status, out_load && o_last_d, state_q == BK_STATUS, "last item outside status step")
endmodule
`default_nettype wire

// ===== rtl/periodic_task_timer_table.sv =====
// top level of the periodic task timer table
// Eight timer slots, each periodic or free-running, with per-kind insertion-order
// lists. A command item goes through a decode register into a two-entry queue, so
// new commands are taken while the execution side is still busy or its result
// waits in the output register. Every command gives exactly one status item, the
// last of its results (last_item high). Each command is popped, executed and
// its status item loaded into the output register; delete first searches its
// list one entry at a time. A process item walks the free-running list and,
// after a tick, the periodic list; for each due periodic slot the
// one-bit-per-cycle restoring divider works out the catch-up count. tick_step
// (reset value 1) is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while no command is in flight, which the block does not enforce.
`default_nettype none
module periodic_task_timer_table (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	ptt_in_if.sink                          req,
	ptt_out_if.source                       rsp,
	input  wire logic                       cfg_wr_en,
	input  wire logic [ptt_pkg::STEP_W-1:0] cfg_wr_data
);
	import ptt_pkg::*;

	// decoded command on its way into the queue
	cmd_t push_cmd;
	logic push_valid;
	logic push_ready;
	// head of the queue toward the execution unit
	cmd_t pop_cmd;
	logic pop_valid;
	logic pop;

	// front: decode and range checks
	ptt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_cmd   (push_cmd),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// queue lets decode and execution stall independently
	ptt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (push_cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_cmd    (pop_cmd),
		.pop_valid  (pop_valid),
		.pop        (pop)
	);

	// back: slot table, process walk, catch-up and result register
	ptt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_cmd       (pop_cmd),
		.q_valid     (pop_valid),
		.q_pop       (pop),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rsp         (rsp)
	);
endmodule
`default_nettype wire
